// ===== src/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;

  typedef logic [31:0] word_t;

  // One queued entry between the front and the back.
  typedef struct packed {
    logic [31:0] data;
    logic        fin;   // last message word of the block stream
  } fe_word_t;

  localparam int unsigned QDepth = 4;

  localparam logic [31:0] PadWord = 32'h8000_0000;
  localparam logic [7:0]  PadByte = 8'h80;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[r];
  endfunction

endpackage

// ===== src/sha256_hash_engine.sv =====
`timescale 1ns / 1ps
// SHA-256 engine. Push message words (big-endian, first byte in bits 31:24)
// with valid_bytes and last_word; after the final word, eight digest words
// appear on the out_ queue, index 0 first. Words go into a four-entry queue,
// so the producer can run ahead while the back is busy. The back loads one
// word per cycle while the queue holds words and runs one round per cycle:
// a block is loaded, then runs 64 rounds and the chaining add; padding may
// add one more such pass, and the digest then leaves at one word per pop.
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_of_digest
);
  localparam int unsigned QW = $clog2(sha_pkg::QDepth);

  sha_pkg::fe_word_t fw;
  logic              fw_two;
  logic [63:0]       fw_len;
  logic              acc;

  sha_pkg::fe_word_t q_w_r [sha_pkg::QDepth];
  logic              q_two_r [sha_pkg::QDepth];
  logic [63:0]       q_len_r [sha_pkg::QDepth];
  logic [QW-1:0]     wp_r, rp_r;
  logic [QW:0]       cnt_r;
  logic              take;

  assign in_full = (cnt_r == (QW+1)'(sha_pkg::QDepth));
  assign acc = in_push && !in_full;

  sha_front u_front (
    .clk, .rst_n, .push(acc), .data_word(in_data_word), .valid_bytes(in_valid_bytes),
    .last_word(in_last_word), .fw, .fw_two, .bit_len(fw_len)
  );

  // Short queue decoupling the front from the back.
  always_ff @(posedge clk) begin
    if (acc) begin
      q_w_r[wp_r] <= fw;
      q_two_r[wp_r] <= fw_two;
      q_len_r[wp_r] <= fw_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (acc) wp_r <= wp_r + QW'(1);
      if (take) rp_r <= rp_r + QW'(1);
      cnt_r <= cnt_r + (QW+1)'(acc) - (QW+1)'(take);
    end
  end

  sha_back u_back (
    .clk, .rst_n, .q_valid(cnt_r != '0), .q_word(q_w_r[rp_r]), .q_two(q_two_r[rp_r]),
    .q_len(q_len_r[rp_r]), .q_take(take), .empty(out_empty), .pop(out_pop),
    .digest_word(out_digest_word), .word_index(out_word_index),
    .last_of_digest(out_last_of_digest)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QW+1)'(sha_pkg::QDepth)) else $error("queue overflow");
  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> cnt_r != '0) else $error("queue underflow");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !take |=> in_full) else $error("full dropped without a read");
endmodule

// ===== src/sha_front.sv =====
`timescale 1ns / 1ps
// Front: masks the final word, appends the pad byte to a partial one, and
// counts message bits. It hands the back one fe_word_t per accepted word;
// the last one carries fin and the masked, padded data (data as is if full).
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [31:0]       data_word,
  input  logic [2:0]        valid_bytes,
  input  logic              last_word,
  output sha_pkg::fe_word_t fw,
  output logic              fw_two,   // full final word: pad goes in a word of its own
  output logic [63:0]       bit_len
);
  logic [63:0] cnt_r, cnt_nxt;
  logic [2:0]  nb;
  logic [31:0] mask;

  always_comb begin
    nb = (!last_word || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    mask = (nb == 3'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - {nb, 3'b000}));
    cnt_nxt = cnt_r + {58'd0, nb, 3'b000};
    fw.fin = last_word;
    fw_two = last_word && nb == 3'd4;
    if (!last_word || nb == 3'd4) begin
      fw.data = data_word;
    end else begin
      fw.data = (data_word & mask) | ({24'd0, sha_pkg::PadByte} << (5'd24 - {nb[1:0], 3'b000}));
    end
    bit_len = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= last_word ? 64'd0 : cnt_nxt;
    end
  end
endmodule

// ===== src/sha_back.sv =====
`timescale 1ns / 1ps
// Back: block buffer, padding sequencer, one-round-per-cycle compression, and
// the digest output queue.
module sha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sha_pkg::fe_word_t q_word,
  input  logic              q_two,
  input  logic [63:0]       q_len,
  output logic              q_take,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_of_digest
);
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [3:0]  wc_r;
  logic [5:0]  rnd_r;
  logic        fin_r;      // the current block carries the length and ends the message
  logic        pend_r;     // a final word arrived and its digest is not yet out
  logic        padx_r;     // an extra 0x80 word is owed
  logic [63:0] len_r;
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [2:0]  oi_r;

  logic        put;
  logic [31:0] put_w;
  logic [31:0] wt, s0, s1, t1, t2, wn;

  always_comb begin
    s0 = sha_pkg::ror32(w_r[1], 7) ^ sha_pkg::ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha_pkg::ror32(w_r[14], 17) ^ sha_pkg::ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    wt = w_r[0];
    t1 = v_r[7] + (sha_pkg::ror32(v_r[4], 6) ^ sha_pkg::ror32(v_r[4], 11)
         ^ sha_pkg::ror32(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha_pkg::round_k(rnd_r) + wt;
    t2 = (sha_pkg::ror32(v_r[0], 2) ^ sha_pkg::ror32(v_r[0], 13)
         ^ sha_pkg::ror32(v_r[0], 22)) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2])
         ^ (v_r[1] & v_r[2]));
  end

  // Word into the block: from the queue while loading, else pad, zero, length.
  always_comb begin
    q_take = 1'b0;
    put = 1'b0;
    put_w = '0;
    unique case (st_r)
      S_LOAD: begin
        if (q_valid) begin
          q_take = 1'b1;
          put = 1'b1;
          put_w = q_word.data;
        end
      end
      S_PAD: begin
        put = 1'b1;
        if (padx_r) begin
          put_w = sha_pkg::PadWord;
        end else if (fin_r && wc_r == 4'd14) begin
          put_w = len_r[63:32];
        end else if (fin_r && wc_r == 4'd15) begin
          put_w = len_r[31:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_LOAD: if (put && (wc_r == 4'd15 || q_word.fin)) st_nxt = (wc_r == 4'd15) ? S_RUN : S_PAD;
      S_PAD:  if (wc_r == 4'd15) st_nxt = S_RUN;
      S_RUN:  if (rnd_r == 6'd63) st_nxt = S_SUM;
      S_SUM:  st_nxt = fin_r ? S_OUT : (pend_r ? S_PAD : S_LOAD);
      S_OUT:  if (pop && oi_r == 3'd7) st_nxt = S_LOAD;
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      wc_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      pend_r <= 1'b0;
      padx_r <= 1'b0;
      oi_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_hash(3'(i));
    end else begin
      st_r <= st_nxt;
      if (put) begin
        w_r[wc_r] <= put_w;
        wc_r <= wc_r + 4'd1;
        if (st_r == S_PAD && padx_r) padx_r <= 1'b0;
      end
      if (q_take && q_word.fin) begin
        padx_r <= q_two;
        len_r <= q_len;
        pend_r <= 1'b1;
        // The length fits in this block only when two words stay free after the pad.
        fin_r <= q_two ? (wc_r <= 4'd12) : (wc_r <= 4'd13);
      end
      if (st_r == S_LOAD && st_nxt == S_RUN || st_r == S_PAD && st_nxt == S_RUN) begin
        rnd_r <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      if (st_r == S_RUN) begin
        rnd_r <= rnd_r + 6'd1;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
        w_r[15] <= wn;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
      end
      if (st_r == S_SUM) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        // The extra padding block that follows always carries the length.
        if (!fin_r && pend_r) fin_r <= 1'b1;
        oi_r <= '0;
      end
      if (st_r == S_OUT && pop) begin
        oi_r <= oi_r + 3'd1;
        if (oi_r == 3'd7) begin
          fin_r <= 1'b0;
          pend_r <= 1'b0;
          for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_hash(3'(i));
        end
      end
    end
  end

  assign empty = (st_r != S_OUT);
  assign digest_word = h_r[oi_r];
  assign word_index = oi_r;
  assign last_of_digest = (oi_r == 3'd7);

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_RUN && rnd_r == 6'd63 |=> st_r == S_SUM) else $error("round count slip");
  a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> fin_r) else $error("digest shown before final block");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == S_LOAD) else $error("queue read while busy");
endmodule

// ===== tb/sha256_hash_engine_tb.sv =====
`timescale 1ns / 1ps
module sha256_hash_engine_tb;

  // Result word as it leaves the engine.
  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        tail;
  } digest_word_t;

  // Software SHA-256 that mirrors the engine word by word. It keeps its own
  // chaining hash, partial block and running bit count, and queues the eight
  // digest words that each final message word produces.
  class digest_scoreboard;
    logic [31:0]  hash_state [8];
    logic [31:0]  block_buf [16];
    int unsigned  fill;
    logic [63:0]  bit_total;
    digest_word_t pending [$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::init_hash(i[2:0]);
      for (int i = 0; i < 16; i++) block_buf[i] = '0;
      fill = 0;
      bit_total = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = block_buf[i];
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          wt = w[r];
        end else begin
          s0 = rotr(w[(r - 15) & 15], 7) ^ rotr(w[(r - 15) & 15], 18) ^ (w[(r - 15) & 15] >> 3);
          s1 = rotr(w[(r - 2) & 15], 17) ^ rotr(w[(r - 2) & 15], 19) ^ (w[(r - 2) & 15] >> 10);
          wt = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
          w[r & 15] = wt;
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(r[5:0]) + wt;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    function void append(logic [31:0] w);
      block_buf[fill] = w;
      fill = (fill + 1) & 15;
      if (fill == 0) compress();
    endfunction

    // Notes one accepted message word.
    function void note_word(logic [31:0] data, logic [2:0] nbytes, logic fin);
      int unsigned n;
      logic [31:0] mask;
      digest_word_t d;
      n = (!fin || nbytes > 4) ? 4 : nbytes;
      bit_total += 64'(n * 8);
      if (!fin) begin
        append(data);
        return;
      end
      if (n == 4) begin
        append(data);
        append(sha_pkg::PadWord);
      end else begin
        mask = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
        append((data & mask) | (32'(sha_pkg::PadByte) << (24 - 8 * n)));
      end
      while (fill != 14) append(32'h0);
      append(bit_total[63:32]);
      append(bit_total[31:0]);
      for (int i = 0; i < 8; i++) begin
        d.digest = hash_state[i];
        d.index  = i[2:0];
        d.tail   = (i == 7);
        pending.push_back(d);
      end
      restart();
    endfunction

    // Checks one popped digest word against the oldest expectation.
    function void check_word(digest_word_t got);
      digest_word_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest word %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.digest !== want.digest) begin
        errors++;
        $display("%0t: digest_word expected %h actual %h", $time, want.digest, got.digest);
      end
      if (got.index !== want.index) begin
        errors++;
        $display("%0t: word_index expected %0d actual %0d", $time, want.index, got.index);
      end
      if (got.tail !== want.tail) begin
        errors++;
        $display("%0t: last_of_digest expected %0d actual %0d", $time, want.tail, got.tail);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [31:0] in_data_word;
  logic [2:0]  in_valid_bytes;
  logic        in_last_word;
  logic        out_empty;
  logic        out_pop;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_of_digest;

  sha256_hash_engine dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_word       (in_data_word),
    .in_valid_bytes     (in_valid_bytes),
    .in_last_word       (in_last_word),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_digest_word    (out_digest_word),
    .out_word_index     (out_word_index),
    .out_last_of_digest (out_last_of_digest)
  );

  digest_scoreboard sb;
  int unsigned cycle_count;
  // Idle percentage on each side; zero during the quiet stretch.
  int unsigned push_idle_pct;
  int unsigned pop_idle_pct;
  // Set while the receiver holds off to let the engine back up.
  bit          hold_pop;

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The scoreboard watches both handshakes at the rising edge, so it sees
  // exactly the words that the engine took and gave.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_word(in_data_word, in_valid_bytes, in_last_word);
      if (out_pop && !out_empty)
        sb.check_word({out_digest_word, out_word_index, out_last_of_digest});
    end
  end

  // Watchdog. The slowest correct run is about 180 words at up to two
  // compression passes per message, plus stalls; the limit leaves ample margin.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("sha256_hash_engine regression: fail");
      $finish;
    end
  end

  // Receiver: pops at the falling edge with random idling. A hold-off
  // stretch is counted here in cycles while the sender keeps pushing.
  initial begin
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_pop) begin
        out_pop <= 1'b0;
        for (int i = 0; i < 600; i++) @(negedge clk);
        hold_pop = 1'b0;
      end
      out_pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Offers one word and waits until the engine takes it. Gaps come first,
  // so push is never dropped and raised in the same step.
  task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                           input logic fin);
    while ($urandom_range(99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push        <= 1'b1;
    in_data_word   <= data;
    in_valid_bytes <= nbytes;
    in_last_word   <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a message of the given number of full words followed by a final
  // word with the given byte count.
  task automatic send_message(input int unsigned full_words, input logic [2:0] tail_bytes);
    for (int i = 0; i < full_words; i++)
      send_word($urandom(), 3'($urandom_range(7)), 1'b0);
    send_word($urandom(), tail_bytes, 1'b1);
  endtask

  initial begin
    sb             = new();
    cycle_count    = 0;
    push_idle_pct  = 8;
    pop_idle_pct   = 8;
    hold_pop       = 1'b0;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_data_word   = '0;
    in_valid_bytes = '0;
    in_last_word   = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty message, extreme data values, every byte count on a
    // last word, valid byte counts above four, and a tail length that forces
    // the extra padding block (13 full words before a full last one).
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'h0000_0000, 3'd7, 1'b1);
    send_word(32'ha5a5_a5a5, 3'd5, 1'b1);
    send_word(32'h5a5a_5a5a, 3'd0, 1'b0);
    send_word(32'hffff_ffff, 3'd6, 1'b1);
    send_message(13, 3'd4);

    // Pressure: stall the receiver a long time while words keep flowing.
    hold_pop = 1'b1;
    send_message(14, 3'd0);
    send_message(3, 3'd2);

    // Quiet stretch with no idling on either side.
    push_idle_pct = 0;
    pop_idle_pct  = 0;
    send_message(15, 3'd3);
    send_message(16, 3'd1);
    push_idle_pct = 8;
    pop_idle_pct  = 8;

    // Random messages, mostly short, some spanning two blocks.
    for (int sent = 0; sent < 90; ) begin
      int unsigned len;
      len = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(16);
      send_message(len, 3'($urandom_range(7)));
      sent += len + 1;
    end
    // Raw noise words, ended by a last word so every one is hashed.
    for (int i = 0; i < 8; i++)
      send_word($urandom(), 3'($urandom_range(7)), 1'($urandom_range(1)));
    send_word($urandom(), 3'($urandom_range(7)), 1'b1);
    in_push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sha256_hash_engine regression: pass");
    end else begin
      $display("sha256_hash_engine regression: fail");
    end
    $finish;
  end

endmodule
